>>> hw/rtl/ultrasonic_echo_ranger_defines.svh
// Assertion macros used by the ranger checker.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UER_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/uer_pkg.sv
// Shared types, register map and phase codes for the echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

    localparam int EDGES_FOR_ECHO = 3;
    localparam int ADDR_W         = 5;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_HALF_PERIOD = 3'd0;
    localparam logic [2:0] REG_EDGE_MIN    = 3'd1;
    localparam logic [2:0] REG_EDGE_MAX    = 3'd2;
    localparam logic [2:0] REG_OVERFLOW    = 3'd3;
    localparam logic [2:0] REG_RINGDOWN    = 3'd4;
    localparam logic [2:0] REG_TIMEOUT     = 3'd5;

    // measurement phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_PULSING   = 3'd1;
    localparam logic [2:0] PH_IGNORING  = 3'd2;
    localparam logic [2:0] PH_WAITING   = 3'd3;
    localparam logic [2:0] PH_RECEIVING = 3'd4;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  edge_min_ticks;
        logic [7:0]  edge_max_ticks;
        logic [15:0] overflow_ticks;
        logic [15:0] quiet_periods;
        logic [15:0] limit_periods;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        half_period_ticks: 16'd100,
        edge_min_ticks:    8'd50,
        edge_max_ticks:    8'd150,
        overflow_ticks:    16'd256,
        quiet_periods:     16'd4,
        limit_periods:     16'd64
    };

    // per-tick outcome handed from the tick stage to the latch stage
    typedef struct packed {
        logic        drive_level;
        logic        busy_res;
        logic        echo_found;
        logic        timed_out;
        logic [15:0] period_count;
        logic [15:0] tick_in_period;
    } mid_t;

endpackage

>>> hw/rtl/uer_if.sv
// Tick and result channel interfaces.
`timescale 1ns / 1ps

interface uer_tick_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] pulse_count;
    logic       echo_edge;

    modport source (output valid, start_req, pulse_count, echo_edge, input ready);
    modport sink   (input valid, start_req, pulse_count, echo_edge, output ready);
endinterface

interface uer_res_if;
    logic        valid;
    logic        ready;
    logic        drive_level;
    logic        busy_res;
    logic        echo_found;
    logic [31:0] echo_time;
    logic        timed_out;

    modport source (output valid, drive_level, busy_res, echo_found, echo_time, timed_out,
                    input ready);
    modport sink   (input valid, drive_level, busy_res, echo_found, echo_time, timed_out,
                    output ready);
endinterface

>>> hw/rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger top level: tick channel in, result channel out, APB config.
// A tick's result is registered in the tick state stage, then in the result stage.
// Throughput: one tick transfer per cycle while results are taken; set by the state loop.
// Three registered stages (input, tick state, result); each moves when the next has room.
// Reset (rst_n low, async): phase idle, counters and pin cleared, echo time zero,
//   configuration back to defaults, pipeline empty. No clearing pass is needed.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
    parameter int EDGES_FOR_ECHO = uer_pkg::EDGES_FOR_ECHO
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [uer_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // channels
    uer_tick_if.sink                   ticks,
    uer_res_if.source                  results
);

    uer_pkg::cfg_t cfg;
    uer_pkg::mid_t mid;

    // stage valids
    logic in_v_reg;
    logic mid_v_reg;
    logic out_v_reg;

    // input register payload
    logic       start_reg;
    logic [7:0] count_reg;
    logic       edge_reg;

    // advance strobes: each stage moves when its downstream slot frees up
    logic move_out;
    logic move_mid;
    logic take_in;

    assign move_out    = mid_v_reg && (!out_v_reg || results.ready);
    assign move_mid    = in_v_reg && (!mid_v_reg || move_out);
    assign ticks.ready = !in_v_reg || move_mid;
    assign take_in     = ticks.valid && ticks.ready;

    uer_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            mid_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (ticks.ready)
            begin
                in_v_reg <= ticks.valid;
            end
            if (!mid_v_reg || move_out)
            begin
                mid_v_reg <= in_v_reg;
            end
            if (!out_v_reg || results.ready)
            begin
                out_v_reg <= mid_v_reg;
            end
        end
    end

    // tick payload capture; no reset, guarded by in_v_reg
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            start_reg <= ticks.start_req;
            count_reg <= ticks.pulse_count;
            edge_reg  <= ticks.echo_edge;
        end
    end

    // all phase/timer/edge state advances once per tick transfer
    uer_ctrl #(
        .EDGES_FOR_ECHO (EDGES_FOR_ECHO)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (move_mid),
        .start_req   (start_reg),
        .pulse_count (count_reg),
        .echo_edge   (edge_reg),
        .cfg         (cfg),
        .mid         (mid)
    );

    // multiply for the echo time sits here, off the state loop
    uer_latch u_latch (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (move_out),
        .mid            (mid),
        .overflow_ticks (cfg.overflow_ticks),
        .drive_level    (results.drive_level),
        .busy_res       (results.busy_res),
        .echo_found     (results.echo_found),
        .echo_time      (results.echo_time),
        .timed_out      (results.timed_out)
    );

    assign results.valid = out_v_reg;

endmodule

>>> hw/rtl/uer_cfg.sv
// APB register file holding the ranger configuration.
`timescale 1ns / 1ps

module uer_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [uer_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output uer_pkg::cfg_t              cfg
);

    uer_pkg::cfg_t cfg_reg;
    uer_pkg::cfg_t cfg_next;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[uer_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                uer_pkg::REG_HALF_PERIOD: cfg_next.half_period_ticks = pwdata[15:0];
                uer_pkg::REG_EDGE_MIN:    cfg_next.edge_min_ticks    = pwdata[7:0];
                uer_pkg::REG_EDGE_MAX:    cfg_next.edge_max_ticks    = pwdata[7:0];
                uer_pkg::REG_OVERFLOW:    cfg_next.overflow_ticks    = pwdata[15:0];
                uer_pkg::REG_RINGDOWN:    cfg_next.quiet_periods     = pwdata[15:0];
                uer_pkg::REG_TIMEOUT:     cfg_next.limit_periods     = pwdata[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            uer_pkg::REG_HALF_PERIOD: prdata = {16'd0, cfg_reg.half_period_ticks};
            uer_pkg::REG_EDGE_MIN:    prdata = {24'd0, cfg_reg.edge_min_ticks};
            uer_pkg::REG_EDGE_MAX:    prdata = {24'd0, cfg_reg.edge_max_ticks};
            uer_pkg::REG_OVERFLOW:    prdata = {16'd0, cfg_reg.overflow_ticks};
            uer_pkg::REG_RINGDOWN:    prdata = {16'd0, cfg_reg.quiet_periods};
            uer_pkg::REG_TIMEOUT:     prdata = {16'd0, cfg_reg.limit_periods};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= uer_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/uer_ctrl.sv
// Tick stage: phase machine, timers and edge qualification.
`timescale 1ns / 1ps

module uer_ctrl #(
    parameter int EDGES_FOR_ECHO = uer_pkg::EDGES_FOR_ECHO
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          start_req,
    input  logic [7:0]    pulse_count,
    input  logic          echo_edge,
    input  uer_pkg::cfg_t cfg,
    output uer_pkg::mid_t mid
);

    localparam logic [2:0] EDGE_GOAL = 3'(EDGES_FOR_ECHO);

    logic [2:0]    phase_reg, phase_next;
    logic [15:0]   period_reg, period_next;
    logic [15:0]   tick_reg, tick_next;
    logic [7:0]    gap_reg, gap_next;
    logic [2:0]    good_reg, good_next;
    logic          pin_reg, pin_next;
    uer_pkg::mid_t mid_reg, mid_next;

    logic [15:0] cmp;
    logic [16:0] tick_inc;
    logic        timer_ev;
    logic [15:0] pc_dec;
    logic [15:0] pc_sat;
    logic [7:0]  gap_now;
    logic [2:0]  good_inc;
    logic        found;
    logic        tout;

    assign cmp      = (phase_reg == uer_pkg::PH_PULSING) ? cfg.half_period_ticks
                                                         : cfg.overflow_ticks;
    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign timer_ev = tick_inc >= {1'b0, cmp};
    assign pc_dec   = (period_reg != 16'd0) ? period_reg - 16'd1 : 16'd0;
    assign pc_sat   = (period_reg == 16'hFFFF) ? 16'hFFFF : period_reg + 16'd1;
    assign gap_now  = (gap_reg == 8'hFF) ? 8'hFF : gap_reg + 8'd1;
    assign good_inc = good_reg + 3'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        period_next = period_reg;
        tick_next   = tick_reg;
        gap_next    = gap_reg;
        good_next   = good_reg;
        pin_next    = pin_reg;
        found       = 1'b0;
        tout        = 1'b0;

        if (phase_reg == uer_pkg::PH_IDLE)
        begin
            if (start_req)
            begin
                phase_next  = uer_pkg::PH_PULSING;
                period_next = {7'd0, pulse_count, 1'b1};
                tick_next   = 16'd0;
                gap_next    = 8'd0;
                good_next   = 3'd0;
                pin_next    = 1'b0;
            end
        end
        else
        begin
            tick_next = timer_ev ? 16'd0 : tick_inc[15:0];

            // timer event goes first
            if (timer_ev)
            begin
                if (phase_reg == uer_pkg::PH_PULSING)
                begin
                    period_next = pc_dec;
                    if (pc_dec != 16'd0)
                    begin
                        pin_next = ~pin_reg;
                    end
                    else
                    begin
                        phase_next = uer_pkg::PH_IGNORING;
                    end
                end
                else if (phase_reg == uer_pkg::PH_IGNORING)
                begin
                    if (period_reg >= cfg.quiet_periods)
                    begin
                        phase_next = uer_pkg::PH_WAITING;
                    end
                    period_next = pc_sat;
                end
                else if (period_reg >= cfg.limit_periods)
                begin
                    phase_next = uer_pkg::PH_IDLE;
                    tout       = 1'b1;
                end
                else
                begin
                    period_next = pc_sat;
                end
            end

            // then gap limit, then the edge itself
            if (phase_next != uer_pkg::PH_IDLE)
            begin
                gap_next = gap_now;
                if (phase_next == uer_pkg::PH_RECEIVING && gap_now >= cfg.edge_max_ticks)
                begin
                    phase_next = uer_pkg::PH_WAITING;
                end
                if (echo_edge)
                begin
                    gap_next = 8'd0;
                    if (phase_next == uer_pkg::PH_WAITING)
                    begin
                        good_next  = 3'd1;
                        phase_next = uer_pkg::PH_RECEIVING;
                    end
                    else if (phase_next == uer_pkg::PH_RECEIVING)
                    begin
                        if (gap_now < cfg.edge_min_ticks)
                        begin
                            phase_next = uer_pkg::PH_WAITING;
                        end
                        else
                        begin
                            good_next = good_inc;
                            if (good_inc >= EDGE_GOAL)
                            begin
                                phase_next = uer_pkg::PH_IDLE;
                                found      = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        mid_next.drive_level    = pin_next;
        mid_next.busy_res       = (phase_next != uer_pkg::PH_IDLE);
        mid_next.echo_found     = found;
        mid_next.timed_out      = tout;
        mid_next.period_count   = period_next;
        mid_next.tick_in_period = tick_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= uer_pkg::PH_IDLE;
            period_reg <= 16'd0;
            tick_reg   <= 16'd0;
            gap_reg    <= 8'd0;
            good_reg   <= 3'd0;
            pin_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            period_reg <= period_next;
            tick_reg   <= tick_next;
            gap_reg    <= gap_next;
            good_reg   <= good_next;
            pin_reg    <= pin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

>>> hw/rtl/uer_latch.sv
// Result stage: echo time product and the output register.
`timescale 1ns / 1ps

module uer_latch (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  uer_pkg::mid_t mid,
    input  logic [15:0]   overflow_ticks,
    output logic          drive_level,
    output logic          busy_res,
    output logic          echo_found,
    output logic [31:0]   echo_time,
    output logic          timed_out
);

    logic [31:0] prod;
    logic [31:0] time_calc;
    logic [31:0] echo_time_reg, echo_time_next;
    logic        drive_reg, busy_reg, found_reg, tout_reg;

    // 16x16 fits in 32 bits, plus tick stays below 2^32
    assign prod           = {16'd0, mid.period_count} * {16'd0, overflow_ticks};
    assign time_calc      = prod + {16'd0, mid.tick_in_period};
    assign echo_time_next = mid.echo_found ? time_calc : echo_time_reg;

    // last latched time is state: reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_time_reg <= 32'd0;
        end
        else if (load)
        begin
            echo_time_reg <= echo_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= mid.drive_level;
            busy_reg  <= mid.busy_res;
            found_reg <= mid.echo_found;
            tout_reg  <= mid.timed_out;
        end
    end

    assign drive_level = drive_reg;
    assign busy_res    = busy_reg;
    assign echo_found  = found_reg;
    assign echo_time   = echo_time_reg;
    assign timed_out   = tout_reg;

endmodule

>>> hw/rtl/uer_checker.sv
// Port-level checks for the echo ranger, bound to the top level.
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_defines.svh"

module uer_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        busy_res,
    input logic        echo_found,
    input logic [31:0] echo_time,
    input logic        timed_out
);

    // stalled result keeps its echo time
    `UER_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(echo_time), "stalled result changed")

    // one tick cannot both confirm an echo and time out
    `UER_ASSERT_SAME(a_end_excl, res_valid, !(echo_found && timed_out), "echo and timeout together")

    // a finished measurement leaves the block idle
    `UER_ASSERT_SAME(a_end_idle, res_valid && (echo_found || timed_out), !busy_res, "busy after measurement end")

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .busy_res   (results.busy_res),
    .echo_found (results.echo_found),
    .echo_time  (results.echo_time),
    .timed_out  (results.timed_out)
);
